>>> hw/rtl/grdc_pkg.sv
package grdc_pkg;

   localparam int unsigned SampleWidth = 64;
   localparam int unsigned FormatWidth = 3;
   localparam int unsigned CsrIndexWidth = 2;

   typedef enum logic [FormatWidth-1:0] {
      FMT_U8     = 3'd0,
      FMT_U16    = 3'd1,
      FMT_U32    = 3'd2,
      FMT_U64    = 3'd3,
      FMT_SINGLE = 3'd4,
      FMT_DOUBLE = 3'd5
   } format_type;

   localparam logic [CsrIndexWidth-1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_FORMAT = 2'd1;

   localparam logic [SampleWidth-1:0] AllOnes = {SampleWidth{1'b1}};

endpackage

>>> hw/rtl/grdc_widen.sv
module grdc_widen (
   input  logic [grdc_pkg::FormatWidth-1:0] fmt,
   input  logic [grdc_pkg::SampleWidth-1:0] sample,
   output logic [grdc_pkg::SampleWidth-1:0] wide
);
   import grdc_pkg::*;

   logic        s_sgn;
   logic [7:0]  s_exp;
   logic [22:0] s_frac;
   logic [63:0] s_man;
   logic [7:0]  s_rsh;
   logic [63:0] s_val;

   logic        d_sgn;
   logic [10:0] d_exp;
   logic [51:0] d_frac;
   logic [63:0] d_man;
   logic [10:0] d_rsh;
   logic [63:0] d_val;

   // single: value * 2^64 = mantissa * 2^(exp - 86)
   always_comb begin
      s_sgn  = sample[31];
      s_exp  = sample[30:23];
      s_frac = sample[22:0];
      s_man  = {40'd0, (s_exp != 8'd0), s_frac};
      s_rsh  = 8'd86 - s_exp;
      if (s_exp == 8'd255) begin
         s_val = (s_frac != 23'd0 || s_sgn) ? '0 : AllOnes;
      end else if (s_sgn) begin
         s_val = '0;
      end else if (s_exp > 8'd126) begin
         s_val = AllOnes;
      end else if (s_exp >= 8'd86) begin
         s_val = s_man << 6'(s_exp - 8'd86);
      end else if (s_rsh >= 8'd24) begin
         s_val = '0;
      end else begin
         s_val = s_man >> s_rsh[4:0];
      end
   end

   // double: value * 2^64 = mantissa * 2^(exp - 1011)
   always_comb begin
      d_sgn  = sample[63];
      d_exp  = sample[62:52];
      d_frac = sample[51:0];
      d_man  = {11'd0, (d_exp != 11'd0), d_frac};
      d_rsh  = 11'd1011 - d_exp;
      if (d_exp == 11'd2047) begin
         d_val = (d_frac != 52'd0 || d_sgn) ? '0 : AllOnes;
      end else if (d_sgn) begin
         d_val = '0;
      end else if (d_exp > 11'd1022) begin
         d_val = AllOnes;
      end else if (d_exp >= 11'd1011) begin
         d_val = d_man << 4'(d_exp - 11'd1011);
      end else if (d_rsh >= 11'd53) begin
         d_val = '0;
      end else begin
         d_val = d_man >> d_rsh[5:0];
      end
   end

   always_comb begin
      case (fmt)
         FMT_U8:     wide = {8{sample[7:0]}};
         FMT_U16:    wide = {4{sample[15:0]}};
         FMT_U32:    wide = {2{sample[31:0]}};
         FMT_U64:    wide = sample;
         FMT_SINGLE: wide = s_val;
         FMT_DOUBLE: wide = d_val;
         default:    wide = '0;
      endcase
   end

endmodule

>>> hw/rtl/grdc_narrow.sv
module grdc_narrow (
   input  logic [grdc_pkg::FormatWidth-1:0] fmt,
   input  logic [grdc_pkg::SampleWidth-1:0] wide,
   output logic [grdc_pkg::SampleWidth-1:0] sample
);
   import grdc_pkg::*;

   logic [5:0]  k;
   logic [95:0] t;
   logic [31:0] hi;
   logic [64:0] fold;
   logic [31:0] quo;
   logic [31:0] mask;

   logic [5:0]  msb;
   logic [63:0] norm;
   logic        s_inc;
   logic [31:0] s_bits;
   logic        d_inc;
   logic [63:0] d_bits;

   // floor(v / rep) = floor((2^k - 1) * v / (2^64 - 1)), folded once
   always_comb begin
      case (fmt)
         FMT_U8:  k = 6'd8;
         FMT_U16: k = 6'd16;
         default: k = 6'd32;
      endcase
      t    = ({32'd0, wide} << k) - {32'd0, wide};
      hi   = t[95:64];
      fold = {1'b0, t[63:0]} + {33'd0, hi};
      quo  = hi + 32'(fold >= {1'b0, AllOnes});
      mask = 32'((33'd1 << k) - 33'd1);
   end

   always_comb begin
      msb = '0;
      for (int i = 0; i < 64; i++) begin
         if (wide[i]) msb = 6'(i);
      end
      norm = wide << (6'd63 - msb);
   end

   // round to nearest even, exponent already lowered by 64
   always_comb begin
      s_inc  = norm[39] & ((|norm[38:0]) | norm[40]);
      s_bits = {1'b0, 8'(8'd63 + {2'b0, msb}), norm[62:40]} + {31'd0, s_inc};
      d_inc  = norm[10] & ((|norm[9:0]) | norm[11]);
      d_bits = {1'b0, 11'(11'd959 + {5'b0, msb}), norm[62:11]} + {63'd0, d_inc};
   end

   always_comb begin
      case (fmt)
         FMT_U8, FMT_U16, FMT_U32: sample = {32'd0, quo & mask};
         FMT_U64:    sample = wide;
         FMT_SINGLE: sample = (wide == '0) ? '0 : {32'd0, s_bits};
         FMT_DOUBLE: sample = (wide == '0) ? '0 : d_bits;
         default:    sample = '0;
      endcase
   end

endmodule

>>> hw/rtl/gamma_ramp_depth_converter.sv
// Converts gamma-ramp entries between 8/16/32/64-bit unsigned, IEEE single and
// IEEE double encodings through a full-range 64-bit value. Integers widen by bit
// replication and narrow by floor division; floats map value*2^64 with clamping
// (NaN gives 0) and come back by round-to-nearest-even. Formats are set through
// the csr port (index 0 source, 1 target), by the user only while the stream is
// idle; the block does not enforce this. One entry is taken per cycle unless
// rsp_tready stalls; each entry and its tlast pass a widen then a narrow stage.
module gamma_ramp_depth_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [grdc_pkg::SampleWidth-1:0]   req_tdata,   // sample_in
   input  logic                               req_tlast,   // last_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [grdc_pkg::SampleWidth-1:0]   rsp_tdata,   // sample_out
   output logic                               rsp_tlast,   // last_out
   input  logic                               csr_we,
   input  logic [grdc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [grdc_pkg::FormatWidth-1:0]   csr_data
);
   import grdc_pkg::*;

   logic [FormatWidth-1:0] src_fmt_ff, tgt_fmt_ff;
   logic                   mid_valid_ff, out_valid_ff;
   logic [SampleWidth-1:0] mid_ff, mid_in, out_ff, out_in;
   logic                   mid_last_ff, out_last_ff;
   logic                   mid_en, out_en;

   assign out_en = !out_valid_ff || rsp_tready;
   assign mid_en = !mid_valid_ff || out_en;
   assign req_tready = mid_en;

   grdc_widen u_widen (.fmt(src_fmt_ff), .sample(req_tdata), .wide(mid_in));
   grdc_narrow u_narrow (.fmt(tgt_fmt_ff), .wide(mid_ff), .sample(out_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff   <= FMT_U8;
         tgt_fmt_ff   <= FMT_U8;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_SOURCE_FORMAT) src_fmt_ff <= csr_data;
         if (csr_we && csr_index == CSR_TARGET_FORMAT) tgt_fmt_ff <= csr_data;
         if (mid_en) mid_valid_ff <= req_tvalid;
         if (out_en) out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_en) begin
         mid_ff      <= mid_in;
         mid_last_ff <= req_tlast;
      end
      if (out_en) begin
         out_ff      <= out_in;
         out_last_ff <= mid_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
